// ===== design/imm_pkg.sv =====
// Shared types and constants for the integer matrix multiplier.
// Used by imm_cell and integer_matrix_multiply; depends on nothing else.
`default_nettype none

package imm_pkg;

  // Input transaction opcodes.
  localparam logic [1:0] OP_WRITE_A = 2'd0;
  localparam logic [1:0] OP_WRITE_B = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  localparam int CFG_WIDTH  = 4;
  localparam int PROD_WIDTH = 35;

  // Control that the sequencer hands to every cell in the row.
  typedef struct packed {
    logic mac;    // accumulate the registered product this cycle
    logic first;  // first term of a dot product: load instead of add
    logic shift;  // take the neighbor's accumulator
  } cell_ctl_t;

  // A dimension of zero counts as one, and one above the maximum as the maximum.
  function automatic logic [4:0] clamp_dim(logic [CFG_WIDTH-1:0] v, logic [4:0] max_dim);
    logic [4:0] res;
    if (v == '0) begin
      res = 5'd1;
    end else if ({1'b0, v} > max_dim) begin
      res = max_dim;
    end else begin
      res = {1'b0, v};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/imm_cell.sv =====
// One cell of the multiply chain: holds one column of B and one accumulator.
// Depends on imm_pkg for the control struct and product width.
`default_nettype none

module imm_cell #(
  parameter int ELEM_WIDTH = 16,
  parameter int MAX_DIM    = 8,
  parameter int DIM_W      = 3
) (
  input  wire                                   clk,
  input  wire imm_pkg::cell_ctl_t               ctl,
  input  wire                                   b_we,
  input  wire        [DIM_W-1:0]                b_waddr,
  input  wire signed [ELEM_WIDTH-1:0]           b_wdata,
  input  wire        [DIM_W-1:0]                rd_addr,
  input  wire signed [ELEM_WIDTH-1:0]           a_value,
  input  wire signed [imm_pkg::PROD_WIDTH-1:0]  acc_in,
  output logic signed [imm_pkg::PROD_WIDTH-1:0] acc_out
);

  logic signed [ELEM_WIDTH-1:0]          b_mem [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0]          b_q;
  logic signed [2*ELEM_WIDTH-1:0]        prod;
  logic signed [imm_pkg::PROD_WIDTH-1:0] prod_ext;
  logic signed [imm_pkg::PROD_WIDTH-1:0] acc;

  // Column store of B, with a registered read.
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= b_wdata;
    end
    b_q <= b_mem[rd_addr];
  end

  // Registered product of the broadcast A element and this column's B element.
  always_ff @(posedge clk) begin
    prod <= a_value * b_q;
  end

  assign prod_ext = imm_pkg::PROD_WIDTH'(prod);

  // Accumulate, or pass results one cell toward the output.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc <= acc_in;
    end else if (ctl.mac) begin
      acc <= ctl.first ? prod_ext : acc + prod_ext;
    end
  end

  assign acc_out = acc;

endmodule

`default_nettype wire

// ===== design/integer_matrix_multiply.sv =====
// Top level of the integer matrix multiplier: A store, sequencer, cell chain.
// Depends on imm_pkg and imm_cell.
//
//   Channel  Signals                                        Direction
//   in       in_valid/in_ready, operation, row/col, value    into block
//   out      out_valid/out_ready, out_row/col, product, flags out of block
//   cfg      cfg_we, cfg_index, cfg_data                     into block
//
// A compute transaction works row by row of A: one inner term per cycle is issued
// through the single A store read port, the terms pass the read, multiply and
// add registers, then results shift out of the chain one column per cycle while
// the output is not stalled.
// Reset restores the dimension registers to one; the stores are not cleared.
// A stalled output holds the chain; no input is taken until a compute finishes.
`default_nettype none

module integer_matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire        [1:0]                      operation,
  input  wire        [2:0]                      row_index,
  input  wire        [2:0]                      col_index,
  input  wire signed [15:0]                     element_value,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic       [2:0]                      out_row,
  output logic       [2:0]                      out_col,
  output logic signed [imm_pkg::PROD_WIDTH-1:0] product_value,
  output logic                                  last,
  output logic                                  dim_error,
  input  wire                                   cfg_we,
  input  wire        [1:0]                      cfg_index,
  input  wire        [imm_pkg::CFG_WIDTH-1:0]   cfg_data
);

  localparam int DIM_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DCW   = $clog2(MAX_DIM + 1);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_UNLOAD = 3'd3;
  localparam logic [2:0] ST_ERR    = 3'd4;

  logic [imm_pkg::CFG_WIDTH-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [DCW-1:0] ar, ac, br, bc;

  logic [2:0]     state, state_next;
  logic [DCW-1:0] r, r_next, k, k_next, c, c_next;

  logic                         in_fire, row_ok, col_ok, out_free, load_out;
  logic signed [ELEM_WIDTH-1:0] elem;
  logic [AW-1:0]                a_waddr, a_raddr;
  logic signed [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic signed [ELEM_WIDTH-1:0] a_q;
  logic                         issue, v1, f1, v2, f2;
  imm_pkg::cell_ctl_t           ctl;

  logic signed [imm_pkg::PROD_WIDTH-1:0] chain [MAX_DIM+1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= imm_pkg::CFG_WIDTH'(1);
      a_cols <= imm_pkg::CFG_WIDTH'(1);
      b_rows <= imm_pkg::CFG_WIDTH'(1);
      b_cols <= imm_pkg::CFG_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        imm_pkg::REG_A_ROWS: a_rows <= cfg_data;
        imm_pkg::REG_A_COLS: a_cols <= cfg_data;
        imm_pkg::REG_B_ROWS: b_rows <= cfg_data;
        imm_pkg::REG_B_COLS: b_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ar = DCW'(imm_pkg::clamp_dim(a_rows, 5'(MAX_DIM)));
  assign ac = DCW'(imm_pkg::clamp_dim(a_cols, 5'(MAX_DIM)));
  assign br = DCW'(imm_pkg::clamp_dim(b_rows, 5'(MAX_DIM)));
  assign bc = DCW'(imm_pkg::clamp_dim(b_cols, 5'(MAX_DIM)));

  // Input side: element writes complete at once.
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign row_ok   = ({2'b0, row_index} < 5'(MAX_DIM));
  assign col_ok   = ({2'b0, col_index} < 5'(MAX_DIM));
  assign elem     = ELEM_WIDTH'(element_value);
  assign a_waddr  = AW'(8'(row_index) * 8'(MAX_DIM) + 8'(col_index));
  assign a_raddr  = AW'(8'(r) * 8'(MAX_DIM) + 8'(k));

  // Store of A, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (in_fire && operation == imm_pkg::OP_WRITE_A && row_ok && col_ok) begin
      a_mem[a_waddr] <= elem;
    end
    a_q <= a_mem[a_raddr];
  end

  assign out_free = !out_valid || out_ready;

  // Sequencer over rows, inner terms and the unload of each row, plus the error result.
  always_comb begin
    state_next = state;
    r_next     = r;
    k_next     = k;
    c_next     = c;
    issue      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && operation == imm_pkg::OP_COMPUTE) begin
          r_next     = '0;
          k_next     = '0;
          state_next = (ac != br) ? ST_ERR : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue  = 1'b1;
        k_next = k + DCW'(1);
        if (k == ac - DCW'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          c_next     = '0;
          state_next = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (out_free) begin
          load_out = 1'b1;
          c_next   = c + DCW'(1);
          if (c == bc - DCW'(1)) begin
            if (r == ar - DCW'(1)) begin
              state_next = ST_IDLE;
            end else begin
              r_next     = r + DCW'(1);
              k_next     = '0;
              state_next = ST_ISSUE;
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
    end
    r  <= r_next;
    k  <= k_next;
    c  <= c_next;
    f1 <= (k == '0);
    f2 <= f1;
  end

  assign ctl.mac   = v2;
  assign ctl.first = f2;
  assign ctl.shift = (state == ST_UNLOAD) && load_out;

  // Chain of cells; cell zero faces the output.
  assign chain[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    logic b_we;
    assign b_we = in_fire && operation == imm_pkg::OP_WRITE_B && row_ok && col_ok
                  && (5'(col_index) == 5'(j));
    imm_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .MAX_DIM   (MAX_DIM),
      .DIM_W     (DIM_W)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .b_we   (b_we),
      .b_waddr(DIM_W'(row_index)),
      .b_wdata(elem),
      .rd_addr(k[DIM_W-1:0]),
      .a_value(a_q),
      .acc_in (chain[j+1]),
      .acc_out(chain[j])
    );
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      if (state == ST_ERR) begin
        out_row       <= 3'd0;
        out_col       <= 3'd0;
        product_value <= '0;
        last          <= 1'b1;
        dim_error     <= 1'b1;
      end else begin
        out_row       <= 3'(r);
        out_col       <= 3'(c);
        product_value <= chain[0];
        last          <= (r == ar - DCW'(1)) && (c == bc - DCW'(1));
        dim_error     <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== dv/integer_matrix_multiply_tb.sv =====
// Self-checking testbench for integer_matrix_multiply: loads A and B, runs computes,
// and compares every product transaction against a behavioral matrix multiplier.
// Depends on imm_pkg and the integer_matrix_multiply RTL.
`default_nettype none

module integer_matrix_multiply_tb;

  localparam int MAXD = 8;
  localparam int LIMIT = 2000000;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] operation;
  logic [2:0] row_index, col_index;
  logic signed [15:0] element_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_row, out_col;
  logic signed [imm_pkg::PROD_WIDTH-1:0] product_value;
  logic last, dim_error;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [imm_pkg::CFG_WIDTH-1:0] cfg_data;

  typedef struct packed {
    logic [2:0] r;
    logic [2:0] c;
    logic signed [imm_pkg::PROD_WIDTH-1:0] val;
    logic lst;
    logic err;
  } product_t;

  // Shadow copies of the stores and the dimension registers.
  logic signed [15:0] a_mirror[MAXD][MAXD];
  logic signed [15:0] b_mirror[MAXD][MAXD];
  logic [imm_pkg::CFG_WIDTH-1:0] dims[4];

  product_t pending_products[$];
  int mismatches = 0;
  int cycles = 0;
  int rx_wait;
  bit hold_off;

  integer_matrix_multiply dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .row_index(row_index), .col_index(col_index),
    .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row(out_row), .out_col(out_col), .product_value(product_value),
    .last(last), .dim_error(dim_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int eff_dim(logic [imm_pkg::CFG_WIDTH-1:0] v);
    if (v == 0) return 1;
    if (v > MAXD) return MAXD;
    return int'(v);
  endfunction

  // Update the shadow stores for a write, or predict the products of a compute.
  task automatic predict_products(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                                  logic signed [15:0] v);
    int ar, ac, br, bc;
    logic signed [imm_pkg::PROD_WIDTH-1:0] acc;
    product_t p;
    ar = eff_dim(dims[imm_pkg::REG_A_ROWS]);
    ac = eff_dim(dims[imm_pkg::REG_A_COLS]);
    br = eff_dim(dims[imm_pkg::REG_B_ROWS]);
    bc = eff_dim(dims[imm_pkg::REG_B_COLS]);
    if (op == imm_pkg::OP_WRITE_A) begin
      a_mirror[r][c] = v;
    end else if (op == imm_pkg::OP_WRITE_B) begin
      b_mirror[r][c] = v;
    end else if (op == imm_pkg::OP_COMPUTE) begin
      if (ac != br) begin
        p = '{r: 3'd0, c: 3'd0, val: '0, lst: 1'b1, err: 1'b1};
        pending_products.push_back(p);
      end else begin
        for (int i = 0; i < ar; i++)
          for (int j = 0; j < bc; j++) begin
            acc = 0;
            for (int k = 0; k < ac; k++)
              acc += imm_pkg::PROD_WIDTH'(a_mirror[i][k]) *
                     imm_pkg::PROD_WIDTH'(b_mirror[k][j]);
            p = '{r: 3'(i), c: 3'(j), val: acc,
                  lst: (i == ar - 1 && j == bc - 1), err: 1'b0};
            pending_products.push_back(p);
          end
      end
    end
  endtask

  // Receiver: waits a random number of cycles after each transaction, and
  // holds off entirely while requested.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = int'($urandom_range(0, 18));
      rx_wait   <= w;
      out_ready <= (w == 0);
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check each product transaction against the oldest prediction.
  always @(posedge clk) begin
    product_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected product at row %0d col %0d", out_row, out_col);
      end else begin
        want = pending_products.pop_front();
        if (want.r !== out_row || want.c !== out_col || want.val !== product_value ||
            want.lst !== last || want.err !== dim_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected r%0d c%0d %0d last%0d err%0d, ",
                      "got r%0d c%0d %0d last%0d err%0d"},
                     want.r, want.c, want.val, want.lst, want.err,
                     out_row, out_col, product_value, last, dim_error);
        end
      end
    end
  end

  // Send one transaction after a random gap; valid stays high on a zero gap.
  task automatic send_item(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                           logic signed [15:0] v, bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    row_index <= r;
    col_index <= c;
    element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_products(op, r, c, v);
  endtask

  // Stop sending and wait until every expected result has come.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_products.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_dims(int ar, int ac, int br, int bc);
    logic [imm_pkg::CFG_WIDTH-1:0] vals[4];
    vals = '{imm_pkg::CFG_WIDTH'(ar), imm_pkg::CFG_WIDTH'(ac),
             imm_pkg::CFG_WIDTH'(br), imm_pkg::CFG_WIDTH'(bc)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      dims[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Fill row zero and column zero of both stores with the most negative value.
  task automatic load_edges();
    for (int i = 0; i < MAXD; i++) begin
      send_item(imm_pkg::OP_WRITE_A, 3'(i), 3'd0, 16'sh8000);
      send_item(imm_pkg::OP_WRITE_B, 3'(i), 3'd0, 16'sh8000);
      if (i != 0) begin
        send_item(imm_pkg::OP_WRITE_A, 3'd0, 3'(i), 16'sh8000);
        send_item(imm_pkg::OP_WRITE_B, 3'd0, 3'(i), 16'sh8000);
      end
    end
  endtask

  // Fill the top-left three by three block of both stores.
  task automatic load_block();
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) begin
        send_item(imm_pkg::OP_WRITE_A, 3'(r), 3'(c), rand_elem());
        send_item(imm_pkg::OP_WRITE_B, 3'(r), 3'(c), rand_elem());
      end
  endtask

  // Directed: extremes, a dimension error, ignored operation, reset dimensions.
  task automatic test_directed();
    send_item(imm_pkg::OP_WRITE_A, 3'd0, 3'd0, 16'sh7fff);
    send_item(imm_pkg::OP_WRITE_B, 3'd0, 3'd0, 16'sh8000);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    send_item(OP_IGNORED, 3'd7, 3'd7, 16'sh1234);
    send_item(imm_pkg::OP_COMPUTE, 3'd7, 3'd7, 16'shffff);
    wait_drain();
    load_edges();
    wait_drain();
    // Largest dot product: eight terms of the most negative value.
    set_dims(1, 8, 8, 1);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    wait_drain();
    // Most results: an eight by eight outer product.
    set_dims(8, 1, 1, 8);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    wait_drain();
    // Mismatched inner dimensions, and zero / out-of-range registers clamped.
    set_dims(2, 3, 4, 2);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    wait_drain();
    set_dims(0, 15, 8, 0);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    wait_drain();
    set_dims(15, 0, 0, 15);
    send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0);
    wait_drain();
  endtask

  // Random: mostly element writes with occasional computes under random sizes.
  task automatic test_random();
    int ar, ac, bc;
    load_block();
    for (int phase = 0; phase < 4; phase++) begin
      wait_drain();
      ar = $urandom_range(1, 3);
      ac = $urandom_range(1, 3);
      bc = $urandom_range(1, 3);
      set_dims(ar, ac, ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 15)) : ac, bc);
      for (int n = 0; n < 14; n++) begin
        if ($urandom_range(0, 5) == 0)
          send_item(($urandom_range(0, 7) == 0) ? OP_IGNORED : imm_pkg::OP_COMPUTE,
                    3'($urandom), 3'($urandom), 16'($urandom));
        else
          send_item(($urandom_range(0, 1) == 0) ? imm_pkg::OP_WRITE_A : imm_pkg::OP_WRITE_B,
                    3'($urandom), 3'($urandom), rand_elem());
      end
    end
    wait_drain();
  endtask

  // Back-pressure: receiver holds off while computes pile up at the input.
  task automatic test_backpressure();
    set_dims(8, 1, 1, 8);
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int n = 0; n < 4; n++) send_item(imm_pkg::OP_COMPUTE, 3'd0, 3'd0, 16'sd0, 1'b1);
    join
    wait_drain();
  endtask

  initial begin
    hold_off = 0;
    rst = 1;
    in_valid = 0;
    operation = imm_pkg::OP_WRITE_A;
    row_index = 0;
    col_index = 0;
    element_value = 0;
    cfg_we = 0;
    cfg_index = imm_pkg::REG_A_ROWS;
    cfg_data = 0;
    for (int i = 0; i < 4; i++) dims[i] = 1;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/imm_pkg.sv
design/imm_cell.sv
design/integer_matrix_multiply.sv
dv/integer_matrix_multiply_tb.sv
